/* hw/rtl/assert_macros.svh */
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with an explicit clock and reset
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked assertion on the usual clock and reset names
`define ASSERT_SYNC(label, prop, msg) \
   `ASSERT_IMPL(label, clock, reset, prop, msg)

`endif

/* hw/rtl/dlr_pkg.sv */
package dlr_pkg;

   // fixed field widths
   localparam int COORD_BITS = 12;
   localparam int COLOR_BITS = 24;
   localparam int LEN_BITS   = COORD_BITS + 1;

   // request opcodes
   typedef enum logic [0:0] {
      OP_START   = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [COORD_BITS-1:0]   x_start;
      logic [COORD_BITS-1:0]   y_start;
      logic [COORD_BITS-1:0]   x_end;
      logic [COORD_BITS-1:0]   y_end;
      logic [COLOR_BITS-1:0]   color_in;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]   pixel_x;
      logic [COORD_BITS-1:0]   pixel_y;
      logic [COLOR_BITS-1:0]   color_out;
      logic                    last;
   } rsp_type;

   // line setup sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROOT,
      ST_DIVIDE
   } seq_state_type;

endpackage

/* hw/rtl/dda_line_rasterizer_top.sv */
// DDA line drawer. A start request (op = OP_START) takes the two end points and the
// color, finds the length as floor(sqrt(dx*dx + dy*dy)) and the per-axis steps
// dx/len and dy/len in signed fixed point with FRAC_BITS fraction bits, truncated
// toward zero; it gives no response and replaces any line in progress. Each advance
// request (op = OP_ADVANCE) then returns one pixel, the integer part of the running
// position plus the color, with last set on the final one; exactly len pixels come
// out and the end point is not drawn. Advances with no line in progress, and a
// start whose end points are equal, give nothing. A start request holds req_ready
// low through the whole line setup, which runs in bit-serial units: a shift-and-add
// squarer one multiplier bit per cycle, a restoring square root one result bit per
// cycle, and two restoring dividers one quotient bit per cycle; a zero-length start
// skips the dividers. Pixels stream at one per cycle while the response side keeps
// taking them; one response register sits on the output.
module dda_line_rasterizer_top import dlr_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int STEP_BITS = FRAC_BITS + 2;

   seq_state_type         state_ff, state_in;
   logic [COORD_BITS-1:0] x0_ff, x0_in, y0_ff, y0_in;
   logic [COORD_BITS-1:0] mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic                  neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;
   logic [LEN_BITS-1:0]   len_ff, len_in;

   logic                  req_fire, start_fire, advance_fire;
   logic [COORD_BITS:0]   diff_x, diff_y, abs_x, abs_y;
   logic                  root_done, div_start, div_done;
   logic [LEN_BITS-1:0]   root_len;
   logic [FRAC_BITS:0]    quo_x, quo_y;
   logic                  load, load_active;
   logic [LEN_BITS-1:0]   load_len;
   logic [STEP_BITS-1:0]  step_x, step_y;

   // request accepted only while idle and the response register can take a pixel
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid || rsp_ready);

   // request decode and end point deltas
   always_comb begin
      req_fire     = req_valid && req_ready;
      start_fire   = req_fire && (req_payload.op == OP_START);
      advance_fire = req_fire && (req_payload.op == OP_ADVANCE);
      diff_x = {1'b0, req_payload.x_end} - {1'b0, req_payload.x_start};
      diff_y = {1'b0, req_payload.y_end} - {1'b0, req_payload.y_start};
      abs_x  = diff_x[COORD_BITS] ? (~diff_x + 1'b1) : diff_x;
      abs_y  = diff_y[COORD_BITS] ? (~diff_y + 1'b1) : diff_y;
   end

   // signed steps from the quotient magnitudes
   always_comb begin
      step_x = neg_x_ff ? (~{1'b0, quo_x} + 1'b1) : {1'b0, quo_x};
      step_y = neg_y_ff ? (~{1'b0, quo_y} + 1'b1) : {1'b0, quo_y};
   end

   // setup sequencer
   always_comb begin
      state_in    = state_ff;
      div_start   = 1'b0;
      load        = 1'b0;
      load_active = 1'b0;
      load_len    = len_ff;
      len_in      = len_ff;
      x0_in       = x0_ff;
      y0_in       = y0_ff;
      mag_x_in    = mag_x_ff;
      mag_y_in    = mag_y_ff;
      neg_x_in    = neg_x_ff;
      neg_y_in    = neg_y_ff;
      color_in    = color_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start_fire) begin
               state_in = ST_ROOT;
               x0_in    = req_payload.x_start;
               y0_in    = req_payload.y_start;
               mag_x_in = abs_x[COORD_BITS-1:0];
               mag_y_in = abs_y[COORD_BITS-1:0];
               neg_x_in = diff_x[COORD_BITS];
               neg_y_in = diff_y[COORD_BITS];
               color_in = req_payload.color_in;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               len_in = root_len;
               if (root_len == '0) begin
                  // zero length: load an idle line and skip the divide
                  load     = 1'b1;
                  load_len = '0;
                  state_in = ST_IDLE;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               load        = 1'b1;
               load_active = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // line setup registers
   always_ff @(posedge clock) begin
      x0_ff    <= x0_in;
      y0_ff    <= y0_in;
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      neg_x_ff <= neg_x_in;
      neg_y_ff <= neg_y_in;
      color_ff <= color_in;
      len_ff   <= len_in;
   end

   dlr_root_unit u_root (
      .clock (clock),
      .reset (reset),
      .start (start_fire),
      .mag_x (abs_x[COORD_BITS-1:0]),
      .mag_y (abs_y[COORD_BITS-1:0]),
      .done  (root_done),
      .root  (root_len)
   );

   dlr_div_unit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .mag_x (mag_x_ff),
      .mag_y (mag_y_ff),
      .len   (root_len),
      .done  (div_done),
      .quo_x (quo_x),
      .quo_y (quo_y)
   );

   dlr_walker #(
      .FRAC_BITS (FRAC_BITS)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .load_active (load_active),
      .load_len    (load_len),
      .load_x      (x0_ff),
      .load_y      (y0_ff),
      .load_step_x (step_x),
      .load_step_y (step_y),
      .load_color  (color_ff),
      .advance     (advance_fire),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

/* hw/rtl/dlr_root_unit.sv */
module dlr_root_unit import dlr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COORD_BITS-1:0] mag_x,
   input  logic [COORD_BITS-1:0] mag_y,
   output logic                  done,
   output logic [LEN_BITS-1:0]   root
);

   localparam int SQ_BITS   = 2 * COORD_BITS + 2;
   localparam int ROOT_BITS = SQ_BITS / 2;
   localparam int REM_BITS  = ROOT_BITS + 2;
   localparam int CNT_BITS  = $clog2(COORD_BITS + 1);
   localparam logic [CNT_BITS-1:0] SQ_LAST   = CNT_BITS'(COORD_BITS - 1);
   localparam logic [CNT_BITS-1:0] ROOT_LAST = CNT_BITS'(ROOT_BITS - 1);

   logic                  busy_ff, busy_in;
   logic                  phase_ff, phase_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [COORD_BITS-1:0] mpl_x_ff, mpl_x_in, mpl_y_ff, mpl_y_in;
   logic [SQ_BITS-1:0]    mcd_x_ff, mcd_x_in, mcd_y_ff, mcd_y_in;
   logic [SQ_BITS-1:0]    sq_ff, sq_in;
   logic [REM_BITS-1:0]   rem_ff, rem_in;
   logic [ROOT_BITS-1:0]  root_ff, root_in;

   logic [SQ_BITS-1:0]    add_x, add_y, sq_sum;
   logic [REM_BITS-1:0]   rem_shift, trial;
   logic                  take;

   // one multiplier bit per cycle, then one root bit per cycle
   always_comb begin
      add_x     = mpl_x_ff[0] ? mcd_x_ff : '0;
      add_y     = mpl_y_ff[0] ? mcd_y_ff : '0;
      sq_sum    = sq_ff + add_x + add_y;
      rem_shift = {rem_ff[REM_BITS-3:0], sq_ff[SQ_BITS-1 -: 2]};
      trial     = {root_ff, 2'b01};
      take      = (rem_shift >= trial);

      busy_in  = busy_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      mpl_x_in = mpl_x_ff;
      mpl_y_in = mpl_y_ff;
      mcd_x_in = mcd_x_ff;
      mcd_y_in = mcd_y_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;

      if (start) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
         cnt_in   = '0;
         mpl_x_in = mag_x;
         mpl_y_in = mag_y;
         mcd_x_in = SQ_BITS'(mag_x);
         mcd_y_in = SQ_BITS'(mag_y);
         sq_in    = '0;
         rem_in   = '0;
         root_in  = '0;
      end else if (busy_ff && !phase_ff) begin
         sq_in    = sq_sum;
         mpl_x_in = mpl_x_ff >> 1;
         mpl_y_in = mpl_y_ff >> 1;
         mcd_x_in = mcd_x_ff << 1;
         mcd_y_in = mcd_y_ff << 1;
         if (cnt_ff == SQ_LAST) begin
            phase_in = 1'b1;
            cnt_in   = '0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end else if (busy_ff) begin
         sq_in = sq_ff << 2;
         if (take) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
         end
         if (cnt_ff == ROOT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   // shift registers
   always_ff @(posedge clock) begin
      mpl_x_ff <= mpl_x_in;
      mpl_y_ff <= mpl_y_in;
      mcd_x_ff <= mcd_x_in;
      mcd_y_ff <= mcd_y_in;
      sq_ff    <= sq_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
   end

   assign done = done_ff;
   assign root = LEN_BITS'(root_ff);

endmodule

/* hw/rtl/dlr_div_unit.sv */
module dlr_div_unit import dlr_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COORD_BITS-1:0] mag_x,
   input  logic [COORD_BITS-1:0] mag_y,
   input  logic [LEN_BITS-1:0]   len,
   output logic                  done,
   output logic [FRAC_BITS:0]    quo_x,
   output logic [FRAC_BITS:0]    quo_y
);

   localparam int REM_BITS = LEN_BITS + 1;
   localparam int CNT_BITS = $clog2(FRAC_BITS + 1);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(FRAC_BITS);

   logic                  busy_ff, busy_in;
   logic                  first_ff, first_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [LEN_BITS-1:0]   len_ff, len_in;
   logic [REM_BITS-1:0]   rem_ff [2];
   logic [REM_BITS-1:0]   rem_in [2];
   logic [FRAC_BITS:0]    quo_ff [2];
   logic [FRAC_BITS:0]    quo_in [2];

   logic [REM_BITS-1:0]   cand [2];
   logic                  fits [2];
   logic [COORD_BITS-1:0] mag [2];

   // restoring division, one quotient bit per lane per cycle
   always_comb begin
      mag[0] = mag_x;
      mag[1] = mag_y;

      busy_in  = busy_ff;
      first_in = first_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      len_in   = len_ff;

      for (int i = 0; i < 2; i++) begin
         cand[i]   = first_ff ? rem_ff[i] : (rem_ff[i] << 1);
         fits[i]   = (cand[i] >= REM_BITS'(len_ff));
         rem_in[i] = rem_ff[i];
         quo_in[i] = quo_ff[i];
         if (start) begin
            rem_in[i] = REM_BITS'(mag[i]);
            quo_in[i] = '0;
         end else if (busy_ff) begin
            rem_in[i] = fits[i] ? (cand[i] - REM_BITS'(len_ff)) : cand[i];
            quo_in[i] = {quo_ff[i][FRAC_BITS-1:0], fits[i]};
         end
      end

      if (start) begin
         busy_in  = 1'b1;
         first_in = 1'b1;
         cnt_in   = '0;
         len_in   = len;
      end else if (busy_ff) begin
         first_in = 1'b0;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         first_ff <= 1'b0;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         first_ff <= first_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   // lane registers
   always_ff @(posedge clock) begin
      len_ff <= len_in;
      for (int i = 0; i < 2; i++) begin
         rem_ff[i] <= rem_in[i];
         quo_ff[i] <= quo_in[i];
      end
   end

   assign done  = done_ff;
   assign quo_x = quo_ff[0];
   assign quo_y = quo_ff[1];

endmodule

/* hw/rtl/dlr_walker.sv */
module dlr_walker import dlr_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  load_active,
   input  logic [LEN_BITS-1:0]   load_len,
   input  logic [COORD_BITS-1:0] load_x,
   input  logic [COORD_BITS-1:0] load_y,
   input  logic [FRAC_BITS+1:0]  load_step_x,
   input  logic [FRAC_BITS+1:0]  load_step_y,
   input  logic [COLOR_BITS-1:0] load_color,
   input  logic                  advance,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output rsp_type               rsp_payload
);

   localparam int STEP_BITS = FRAC_BITS + 2;
   localparam int ACC_BITS  = COORD_BITS + FRAC_BITS + 1;
   localparam int EXT_BITS  = ACC_BITS - STEP_BITS;

   logic                  active_ff, active_in;
   logic [LEN_BITS-1:0]   remaining_ff, remaining_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ACC_BITS-1:0]   acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [STEP_BITS-1:0]  step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  emit, final_pixel;
   logic [ACC_BITS-1:0]   step_x_ext, step_y_ext;

   // position update and output register
   always_comb begin
      emit        = advance && active_ff;
      final_pixel = (remaining_ff == LEN_BITS'(1));
      step_x_ext  = {{EXT_BITS{step_x_ff[STEP_BITS-1]}}, step_x_ff};
      step_y_ext  = {{EXT_BITS{step_y_ff[STEP_BITS-1]}}, step_y_ff};

      active_in    = active_ff;
      remaining_in = remaining_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      step_x_in    = step_x_ff;
      step_y_in    = step_y_ff;
      color_in     = color_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (load) begin
         active_in    = load_active;
         remaining_in = load_len;
         acc_x_in     = {1'b0, load_x, {FRAC_BITS{1'b0}}};
         acc_y_in     = {1'b0, load_y, {FRAC_BITS{1'b0}}};
         step_x_in    = load_step_x;
         step_y_in    = load_step_y;
         color_in     = load_color;
      end else if (emit) begin
         rsp_in.pixel_x   = acc_x_ff[FRAC_BITS +: COORD_BITS];
         rsp_in.pixel_y   = acc_y_ff[FRAC_BITS +: COORD_BITS];
         rsp_in.color_out = color_ff;
         rsp_in.last      = final_pixel;
         rsp_valid_in     = 1'b1;
         acc_x_in         = acc_x_ff + step_x_ext;
         acc_y_in         = acc_y_ff + step_y_ext;
         remaining_in     = remaining_ff - 1'b1;
         active_in        = !final_pixel;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      acc_x_ff  <= acc_x_in;
      acc_y_ff  <= acc_y_in;
      step_x_ff <= step_x_in;
      step_y_ff <= step_y_in;
      color_ff  <= color_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* hw/rtl/dlr_checker.sv */
`include "assert_macros.svh"

module dlr_checker import dlr_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // a pending response stays until taken
   `ASSERT_SYNC(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")

   // a stalled response keeps its pixel
   `ASSERT_SYNC(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_payload), "response changed while stalled")

   // every new response follows an accepted advance request
   `ASSERT_SYNC(a_rsp_cause, rsp_valid && !$past(rsp_valid && !rsp_ready) |-> $past(req_valid && req_ready && req_payload.op == OP_ADVANCE), "response without an advance request")

   // line setup holds off the next request
   `ASSERT_SYNC(a_start_busy, req_valid && req_ready && req_payload.op == OP_START |=> !req_ready, "request taken during line setup")

endmodule

bind dda_line_rasterizer_top dlr_checker u_checker (.*);
